// ===== hdl/csb_pkg.sv =====
// Shared types and constants for the counting semaphore bank.
package csb_pkg;

  // Default sizes
  localparam int unsigned NUM_RESOURCES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF   = 16;
  localparam int unsigned PID_BITS_DEF      = 8;

  // Fixed field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PIDIN_W = 8;
  localparam int unsigned RIDX_W  = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned CFG_W   = 64;

  // Count limits
  localparam logic signed [CNT_W-1:0] CNT_MAX = 9'sd255;
  localparam logic signed [CNT_W-1:0] CNT_MIN = -9'sd256;

  // Commands
  localparam logic [CMD_W-1:0] CMD_WAIT        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SIGNAL      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXIT        = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EXIT_ALIAS  = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_GRANTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_BLOCKED = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_RES  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  // Configuration register indexes
  localparam logic CFG_RES_IN_USE  = 1'b0;
  localparam logic CFG_INIT_COUNTS = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_PROC,
    S_PASS_END,
    S_WAKE_CHK,
    S_DONE
  } csb_state_e;

  // Which queue walk is running
  typedef enum logic [1:0] {
    PH_SELF,
    PH_HEAD,
    PH_PURGE
  } csb_phase_e;

endpackage

// ===== hdl/counting_semaphore_bank_fifo_waiters_core.sv =====
// Top level of the counting semaphore bank with FIFO wait queues.
//
// Usage: pulse start_i with command_i, process_id_i and resource_index_i;
// the transfer happens at an edge where start_i is high and busy_o is low.
// Exactly one result follows: done_o is high for one cycle while status_o,
// count_after_o, woken_valid_o and woken_pid_o hold the result. The
// receiver cannot stall; the result is taken in that cycle.
// Configuration: cfg_we_i with cfg_idx_i selects resources_in_use (0) or
// initial_counts (1); writing initial_counts loads all counts at once.
// Write only while busy_o is low.
// Sequence: wait and unknown resource go from decode straight to done.
// A signal walks the addressed queue, optionally the head removal walk,
// and for exit one walk per valid queue; each queue entry takes a read
// state and a process state on the single-read slot memory.
// One command is handled at a time.
// Reset: counts, occupancies and resources_in_use are zero; the slot
// memory is not cleared and needs no clearing pass.
module counting_semaphore_bank_fifo_waiters_core import csb_pkg::*; #(
  parameter int unsigned NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int unsigned PID_BITS      = PID_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [PIDIN_W-1:0]      process_id_i,
  input  logic [RIDX_W-1:0]       resource_index_i,
  output logic                    done_o,
  output logic [STAT_W-1:0]       status_o,
  output logic signed [CNT_W-1:0] count_after_o,
  output logic                    woken_valid_o,
  output logic [PIDIN_W-1:0]      woken_pid_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned DEPTH  = NUM_RESOURCES * QUEUE_DEPTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [RIDX_W-1:0]   rin_q;
  logic [RIDX_W-1:0]   nres;
  logic                cnt_load;
  logic                we, re;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [PID_BITS-1:0] wdata, rdata;

  // resources_in_use register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rin_q <= '0;
    end else if (cfg_we_i && cfg_idx_i == CFG_RES_IN_USE) begin
      rin_q <= cfg_wdata_i[RIDX_W-1:0];
    end
  end

  assign nres     = (rin_q > RIDX_W'(NUM_RESOURCES)) ? RIDX_W'(NUM_RESOURCES) : rin_q;
  assign cnt_load = cfg_we_i && cfg_idx_i == CFG_INIT_COUNTS;

  csb_ctrl #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PID_BITS      (PID_BITS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i,
    .command_i,
    .process_id_i,
    .resource_index_i,
    .busy_o,
    .nres_i        (nres),
    .cnt_load_i    (cnt_load),
    .init_counts_i (cfg_wdata_i),
    .done_o,
    .status_o,
    .count_after_o,
    .woken_valid_o,
    .woken_pid_o,
    .mem_we_o      (we),
    .mem_waddr_o   (waddr),
    .mem_wdata_o   (wdata),
    .mem_re_o      (re),
    .mem_raddr_o   (raddr),
    .mem_rdata_i   (rdata)
  );

  csb_slot_ram #(
    .DEPTH (DEPTH),
    .WIDTH (PID_BITS)
  ) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ===== hdl/csb_slot_ram.sv =====
// Waiter slot memory: one write port, one read port, registered read data.
module csb_slot_ram import csb_pkg::*; #(
  parameter int unsigned DEPTH = NUM_RESOURCES_DEF * QUEUE_DEPTH_DEF,
  parameter int unsigned WIDTH = PID_BITS_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/csb_ctrl.sv =====
// Command sequencer: counts, occupancies and queue walks over the slot memory.
module csb_ctrl import csb_pkg::*; #(
  parameter int unsigned NUM_RESOURCES = NUM_RESOURCES_DEF,
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int unsigned PID_BITS      = PID_BITS_DEF,
  localparam int unsigned RES_W  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1,
  localparam int unsigned OCC_W  = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned ADDR_W = $clog2(NUM_RESOURCES * QUEUE_DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command channel
  input  logic                       start_i,
  input  logic [CMD_W-1:0]           command_i,
  input  logic [PIDIN_W-1:0]         process_id_i,
  input  logic [RIDX_W-1:0]          resource_index_i,
  output logic                       busy_o,
  // configuration
  input  logic [RIDX_W-1:0]          nres_i,
  input  logic                       cnt_load_i,
  input  logic [CFG_W-1:0]           init_counts_i,
  // result channel
  output logic                       done_o,
  output logic [STAT_W-1:0]          status_o,
  output logic signed [CNT_W-1:0]    count_after_o,
  output logic                       woken_valid_o,
  output logic [PIDIN_W-1:0]         woken_pid_o,
  // slot memory
  output logic                       mem_we_o,
  output logic [ADDR_W-1:0]          mem_waddr_o,
  output logic [PID_BITS-1:0]        mem_wdata_o,
  output logic                       mem_re_o,
  output logic [ADDR_W-1:0]          mem_raddr_o,
  input  logic [PID_BITS-1:0]        mem_rdata_i
);

  csb_state_e state_q, state_d;
  csb_phase_e ph_q;

  logic [CMD_W-1:0]        cmd_q;
  logic [PID_BITS-1:0]     pid_q;
  logic [RIDX_W-1:0]       idx_q;
  logic [RIDX_W-1:0]       r_q;
  logic [OCC_W-1:0]        k_q;
  logic                    found_q;
  logic [STAT_W-1:0]       stat_q;
  logic                    wv_q;
  logic [PID_BITS-1:0]     wpid_q;
  logic                    done_q;

  logic signed [CNT_W-1:0] cnt_q [NUM_RESOURCES];
  logic [OCC_W-1:0]        occ_q [NUM_RESOURCES];

  logic [RES_W-1:0]        idx_s, r_s;
  logic                    is_err, is_exit, wake_ok, match, q_full;
  logic signed [CNT_W-1:0] c_idx;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [RES_W-1:0] r,
                                                  input logic [OCC_W-1:0] k);
    return ADDR_W'(r) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(k);
  endfunction

  assign idx_s   = idx_q[RES_W-1:0];
  assign r_s     = r_q[RES_W-1:0];
  assign c_idx   = cnt_q[idx_s];
  assign is_err  = (idx_q >= nres_i);
  assign is_exit = (cmd_q == CMD_EXIT) || (cmd_q == CMD_EXIT_ALIAS);
  assign wake_ok = (c_idx <= 9'sd0) && (occ_q[idx_s] != '0);
  assign q_full  = (occ_q[idx_s] >= OCC_W'(QUEUE_DEPTH));
  assign match   = (ph_q == PH_HEAD) ? (k_q == '0) : (mem_rdata_i == pid_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (start_i) state_d = S_DECODE;
      S_DECODE: begin
        if (is_err || cmd_q == CMD_WAIT) state_d = S_DONE;
        else                             state_d = S_RD;
      end
      S_RD:       state_d = (k_q == occ_q[r_s]) ? S_PASS_END : S_PROC;
      S_PROC:     state_d = S_RD;
      S_PASS_END: begin
        unique case (ph_q)
          PH_SELF:  state_d = S_WAKE_CHK;
          PH_HEAD:  state_d = is_exit ? S_RD : S_DONE;
          PH_PURGE: state_d = ((r_q + 1'b1) < nres_i) ? S_RD : S_DONE;
          default:  state_d = S_DONE;
        endcase
      end
      S_WAKE_CHK: state_d = (wake_ok || is_exit) ? S_RD : S_DONE;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Outputs to the handshake and the slot memory
  always_comb begin
    busy_o      = (state_q != S_IDLE);
    mem_re_o    = (state_q == S_RD) && (k_q != occ_q[r_s]);
    mem_raddr_o = slot_addr(r_s, k_q);
    mem_we_o    = 1'b0;
    mem_waddr_o = slot_addr(r_s, k_q - 1'b1);
    mem_wdata_o = mem_rdata_i;
    if (state_q == S_DECODE) begin
      // append to the tail on a blocking wait
      mem_we_o    = !is_err && cmd_q == CMD_WAIT && c_idx <= 9'sd0 && !q_full;
      mem_waddr_o = slot_addr(idx_s, occ_q[idx_s]);
      mem_wdata_o = pid_q;
    end else if (state_q == S_PROC) begin
      // close the gap behind the removed entry
      mem_we_o = found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath and per-resource state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q          <= PH_SELF;
      cmd_q         <= CMD_WAIT;
      pid_q         <= '0;
      idx_q         <= '0;
      r_q           <= '0;
      k_q           <= '0;
      found_q       <= 1'b0;
      stat_q        <= ST_GRANTED;
      wv_q          <= 1'b0;
      wpid_q        <= '0;
      done_q        <= 1'b0;
      status_o      <= ST_GRANTED;
      count_after_o <= '0;
      woken_valid_o <= 1'b0;
      woken_pid_o   <= '0;
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        cnt_q[i] <= '0;
        occ_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_q  <= command_i;
            pid_q  <= PID_BITS'(process_id_i);
            idx_q  <= resource_index_i;
            stat_q <= ST_GRANTED;
            wv_q   <= 1'b0;
            wpid_q <= '0;
          end
        end
        S_DECODE: begin
          if (is_err) begin
            stat_q <= ST_NO_RES;
          end else if (cmd_q == CMD_WAIT) begin
            if (c_idx <= 9'sd0) begin
              if (q_full) begin
                stat_q <= ST_FULL;
              end else begin
                stat_q        <= ST_BLOCKED;
                occ_q[idx_s]  <= occ_q[idx_s] + 1'b1;
                if (c_idx != CNT_MIN) cnt_q[idx_s] <= c_idx - 1'b1;
              end
            end else begin
              cnt_q[idx_s] <= c_idx - 1'b1;
            end
          end else begin
            // signal or exit: bump, then walk the own queue for the caller
            if (c_idx != CNT_MAX) cnt_q[idx_s] <= c_idx + 1'b1;
            r_q     <= idx_q;
            k_q     <= '0;
            found_q <= 1'b0;
            ph_q    <= PH_SELF;
          end
        end
        S_RD: ;
        S_PROC: begin
          if (!found_q && match) begin
            found_q <= 1'b1;
            if (ph_q == PH_HEAD) begin
              wv_q   <= 1'b1;
              wpid_q <= mem_rdata_i;
            end
          end
          k_q <= k_q + 1'b1;
        end
        S_PASS_END: begin
          if (found_q) begin
            occ_q[r_s] <= occ_q[r_s] - 1'b1;
            if (ph_q == PH_PURGE && cnt_q[r_s] != CNT_MAX) cnt_q[r_s] <= cnt_q[r_s] + 1'b1;
          end
          k_q     <= '0;
          found_q <= 1'b0;
          if (ph_q == PH_HEAD) begin
            ph_q <= PH_PURGE;
            r_q  <= '0;
          end else if (ph_q == PH_PURGE) begin
            r_q <= r_q + 1'b1;
          end
        end
        S_WAKE_CHK: begin
          if (wake_ok) begin
            ph_q <= PH_HEAD;
            r_q  <= idx_q;
          end else begin
            ph_q <= PH_PURGE;
            r_q  <= '0;
          end
        end
        S_DONE: begin
          done_q        <= 1'b1;
          status_o      <= stat_q;
          count_after_o <= is_err ? '0 : c_idx;
          woken_valid_o <= wv_q;
          woken_pid_o   <= PIDIN_W'(wpid_q);
        end
        default: ;
      endcase
      // initial count register write loads every count at once
      if (cnt_load_i) begin
        for (int i = 0; i < NUM_RESOURCES; i++) begin
          cnt_q[i] <= $signed({1'b0, init_counts_i[8*i +: 8]});
        end
      end
    end
  end

  assign done_o = done_q;

  a_done_after_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_DONE))
    else $error("result strobe without finishing state");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q[r_s] <= OCC_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_proc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROC) |-> (k_q < occ_q[r_s]))
    else $error("walk read beyond occupancy");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_PROC || state_q == S_DECODE))
    else $error("slot write outside append or compaction");

endmodule
